/* rtl/core/playfair_cipher_encrypt_core_defines.svh */
// assertion macros for the playfair encryptor checker
`ifndef PLAYFAIR_CIPHER_ENCRYPT_CORE_DEFINES_SVH
`define PLAYFAIR_CIPHER_ENCRYPT_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define PF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define PF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/pf_pkg.sv */
// shared types, constants and helpers for the playfair encryptor
package pf_pkg;

    localparam int SQUARE_SIDE = 5;
    localparam int CELLS       = SQUARE_SIDE * SQUARE_SIDE;
    localparam int LETTERS     = 26;

    typedef logic [4:0] letter_t;
    typedef logic [4:0] cell_t;
    typedef logic [2:0] coord_t;

    localparam letter_t IDX_I = 5'd8;
    localparam letter_t IDX_J = 5'd9;
    localparam letter_t IDX_X = 5'd23;

    localparam logic [7:0] ASCII_UC_A = 8'h41;
    localparam logic [7:0] ASCII_UC_Z = 8'h5A;
    localparam logic [7:0] ASCII_LC_A = 8'h61;
    localparam logic [7:0] ASCII_LC_Z = 8'h7A;
    localparam logic [7:0] ASCII_CASE = 8'h20;
    localparam logic [6:0] LETTER_BASE = 7'h41;

    typedef enum logic [1:0] {
        REQ_KEY_BYTE  = 2'd0,
        REQ_KEY_END   = 2'd1,
        REQ_TEXT_BYTE = 2'd2,
        REQ_TEXT_END  = 2'd3
    } req_type_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_POS_A,
        ST_POS_B,
        ST_CELL_X,
        ST_CELL_Y,
        ST_OUT_X,
        ST_OUT_Y
    } state_t;

    // placement request into the key store
    typedef struct packed {
        logic    clear;
        logic    place;
        letter_t idx;
    } ks_req_t;

    typedef struct packed {
        logic    ok;
        letter_t idx;
    } norm_t;

    // upper-case, fold j onto i, flag non-letters
    function automatic norm_t norm_letter(logic [7:0] b);
        logic [7:0] v;
        norm_t      n;
        v = b;
        if (v >= ASCII_LC_A && v <= ASCII_LC_Z) begin
            v = v - ASCII_CASE;
        end
        n.ok  = (v >= ASCII_UC_A) && (v <= ASCII_UC_Z);
        n.idx = 5'(v - ASCII_UC_A);
        if (n.idx == IDX_J) begin
            n.idx = IDX_I;
        end
        return n;
    endfunction

endpackage

/* rtl/core/pf_keystore.sv */
// key square, letter positions, used flags and fill count
module pf_keystore
    import pf_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  ks_req_t req,
    input  letter_t pos_addr,
    output cell_t   pos_data,
    input  cell_t   cell_addr,
    output letter_t cell_data
);

    letter_t              key_square_reg      [CELLS];
    cell_t                letter_position_reg [LETTERS];
    logic [LETTERS-1:0]   used_reg;
    logic [LETTERS-1:0]   used_next;
    logic [4:0]           fill_reg;
    logic [4:0]           fill_next;
    logic [LETTERS-1:0]   used_eff;
    logic [4:0]           fill_eff;
    logic                 do_place;

    // a new key clears the flags in the same cycle its first letter lands
    always_comb begin
        used_eff  = req.clear ? '0 : used_reg;
        fill_eff  = req.clear ? '0 : fill_reg;
        do_place  = req.place && !used_eff[req.idx] && (fill_eff < 5'(CELLS));
        used_next = used_eff;
        fill_next = fill_eff;
        if (do_place) begin
            used_next[req.idx] = 1'b1;
            fill_next          = fill_eff + 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
            fill_reg <= '0;
        end else begin
            used_reg <= used_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_place) begin
            key_square_reg[fill_eff]       <= req.idx;
            letter_position_reg[req.idx]   <= fill_eff;
        end
    end

    assign pos_data  = letter_position_reg[pos_addr];
    assign cell_data = key_square_reg[cell_addr];

endmodule

/* rtl/core/pf_cell_unit.sv */
// shared row/column rule unit: picks the cipher cell for either letter of a pair
module pf_cell_unit
    import pf_pkg::*;
(
    input  cell_t pos_a,
    input  cell_t pos_b,
    input  logic  sel_second,
    output cell_t cell_idx
);

    function automatic coord_t pos_row(cell_t pos);
        coord_t row;
        row = '0;
        for (int r = 1; r < SQUARE_SIDE; r++) begin
            if (pos >= 5'(r * SQUARE_SIDE)) begin
                row = 3'(r);
            end
        end
        return row;
    endfunction

    function automatic coord_t wrap_inc(coord_t v);
        return (v == 3'(SQUARE_SIDE - 1)) ? '0 : v + 3'd1;
    endfunction

    coord_t r1, c1, r2, c2;
    coord_t r_sel, c_sel;
    coord_t row_o, col_o;

    always_comb begin
        r1    = pos_row(pos_a);
        r2    = pos_row(pos_b);
        c1    = 3'(pos_a - 5'(r1 * SQUARE_SIDE));
        c2    = 3'(pos_b - 5'(r2 * SQUARE_SIDE));
        r_sel = sel_second ? r2 : r1;
        c_sel = sel_second ? c2 : c1;
        if (r1 == r2) begin
            row_o = r_sel;
            col_o = wrap_inc(c_sel);
        end else if (c1 == c2) begin
            row_o = wrap_inc(r_sel);
            col_o = c_sel;
        end else begin
            // rectangle: keep own row, take the partner's column
            row_o = r_sel;
            col_o = sel_second ? c1 : c2;
        end
        cell_idx = 5'(row_o * SQUARE_SIDE) + 5'(col_o);
    end

endmodule

/* rtl/core/playfair_cipher_encrypt_core.sv */
// playfair 5x5 encryptor top level: sequencer over one key store and one cell unit
// keyword byte: placed while idle; keyword end: a sweep over the alphabet fills the square
// pair-completing text word: reads both positions, then both cipher cells, shows the first
// cipher letter and, once taken, the second, then ready again; set by the single position and
// square read ports; other text words keep it idle; results wait in place while m_ready is low
// synchronous reset clears the used flags, fill count, pending pair and ready flag at once
module playfair_cipher_encrypt_core
    import pf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_req_type,
    input  logic [7:0] s_data_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [6:0] m_cipher_letter,
    output logic       m_last
);

    state_t    state_reg, state_next;
    logic      square_ready_reg, square_ready_next;
    logic      pending_valid_reg, pending_valid_next;
    letter_t   pending_letter_reg, pending_letter_next;
    letter_t   k_reg, k_next;
    letter_t   a_reg, a_next;
    letter_t   b_reg, b_next;
    logic      last_reg, last_next;
    cell_t     pa_reg, pa_next;
    cell_t     pb_reg, pb_next;
    letter_t   x_reg, x_next;
    letter_t   y_reg, y_next;

    logic      s_accept;
    req_type_t req;
    norm_t     norm;
    logic      start_fill;
    logic      start_pair;

    ks_req_t   ks_req;
    letter_t   pos_addr;
    cell_t     pos_data;
    cell_t     cell_addr;
    letter_t   cell_data;
    logic      cell_sel;

    pf_keystore u_keystore (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (ks_req),
        .pos_addr  (pos_addr),
        .pos_data  (pos_data),
        .cell_addr (cell_addr),
        .cell_data (cell_data)
    );

    pf_cell_unit u_cell_unit (
        .pos_a      (pa_reg),
        .pos_b      (pb_reg),
        .sel_second (cell_sel),
        .cell_idx   (cell_addr)
    );

    assign s_accept = s_valid && s_ready;
    assign req      = req_type_t'(s_req_type);
    assign norm     = norm_letter(s_data_byte);

    always_comb begin
        start_fill = (req == REQ_KEY_END) && !square_ready_reg;
        start_pair = square_ready_reg && pending_valid_reg &&
                     (((req == REQ_TEXT_BYTE) && norm.ok) || (req == REQ_TEXT_END));
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && start_fill) begin
                    state_next = ST_FILL;
                end else if (s_accept && start_pair) begin
                    state_next = ST_POS_A;
                end
            end
            ST_FILL: begin
                if (k_reg == 5'(LETTERS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_POS_A:  state_next = ST_POS_B;
            ST_POS_B:  state_next = ST_CELL_X;
            ST_CELL_X: state_next = ST_CELL_Y;
            ST_CELL_Y: state_next = ST_OUT_X;
            ST_OUT_X: begin
                if (m_ready) begin
                    state_next = ST_OUT_Y;
                end
            end
            ST_OUT_Y: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs and unit controls
    always_comb begin
        s_ready         = (state_reg == ST_IDLE);
        m_valid         = (state_reg == ST_OUT_X) || (state_reg == ST_OUT_Y);
        m_cipher_letter = 7'((state_reg == ST_OUT_Y) ? y_reg : x_reg) + LETTER_BASE;
        m_last          = (state_reg == ST_OUT_Y) && last_reg;
        pos_addr        = (state_reg == ST_POS_B) ? b_reg : a_reg;
        cell_sel        = (state_reg == ST_CELL_Y);
        ks_req          = '0;
        if (state_reg == ST_IDLE && s_accept && req == REQ_KEY_BYTE) begin
            ks_req.clear = square_ready_reg;
            ks_req.place = norm.ok;
            ks_req.idx   = norm.idx;
        end else if (state_reg == ST_FILL) begin
            ks_req.place = (k_reg != IDX_J);
            ks_req.idx   = k_reg;
        end
    end

    // datapath
    always_comb begin
        square_ready_next   = square_ready_reg;
        pending_valid_next  = pending_valid_reg;
        pending_letter_next = pending_letter_reg;
        k_next              = k_reg;
        a_next              = a_reg;
        b_next              = b_reg;
        last_next           = last_reg;
        pa_next             = pa_reg;
        pb_next             = pb_reg;
        x_next              = x_reg;
        y_next              = y_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    case (req)
                        REQ_KEY_BYTE: begin
                            if (square_ready_reg) begin
                                square_ready_next   = 1'b0;
                                pending_valid_next  = 1'b0;
                                pending_letter_next = '0;
                            end
                        end
                        REQ_KEY_END: begin
                            if (start_fill) begin
                                k_next              = '0;
                                pending_valid_next  = 1'b0;
                                pending_letter_next = '0;
                            end
                        end
                        REQ_TEXT_BYTE: begin
                            if (square_ready_reg && norm.ok) begin
                                if (!pending_valid_reg) begin
                                    pending_letter_next = norm.idx;
                                    pending_valid_next  = 1'b1;
                                end else begin
                                    a_next    = pending_letter_reg;
                                    last_next = 1'b0;
                                    if (norm.idx == pending_letter_reg) begin
                                        // doubled letter: x goes in, the letter opens the next pair
                                        b_next = IDX_X;
                                    end else begin
                                        b_next              = norm.idx;
                                        pending_valid_next  = 1'b0;
                                        pending_letter_next = '0;
                                    end
                                end
                            end
                        end
                        REQ_TEXT_END: begin
                            if (start_pair) begin
                                a_next              = pending_letter_reg;
                                b_next              = IDX_X;
                                last_next           = 1'b1;
                                pending_valid_next  = 1'b0;
                                pending_letter_next = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_FILL: begin
                k_next = k_reg + 5'd1;
                if (k_reg == 5'(LETTERS - 1)) begin
                    square_ready_next = 1'b1;
                end
            end
            ST_POS_A:  pa_next = pos_data;
            ST_POS_B:  pb_next = pos_data;
            ST_CELL_X: x_next  = cell_data;
            ST_CELL_Y: y_next  = cell_data;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            square_ready_reg   <= 1'b0;
            pending_valid_reg  <= 1'b0;
            pending_letter_reg <= '0;
            k_reg              <= '0;
        end else begin
            state_reg          <= state_next;
            square_ready_reg   <= square_ready_next;
            pending_valid_reg  <= pending_valid_next;
            pending_letter_reg <= pending_letter_next;
            k_reg              <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        last_reg <= last_next;
        pa_reg   <= pa_next;
        pb_reg   <= pb_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
    end

endmodule

/* rtl/core/pf_checker.sv */
// port-level checker for the playfair encryptor, bound to the top level
`include "playfair_cipher_encrypt_core_defines.svh"

module pf_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [1:0] s_req_type,
    input logic [7:0] s_data_byte,
    input logic       m_valid,
    input logic       m_ready,
    input logic [6:0] m_cipher_letter,
    input logic       m_last
);

    // a stalled result word holds
    `PF_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_cipher_letter) && $stable(m_last), "result word changed while stalled")

    // cipher letters are always upper case
    `PF_ASSERT_NOW(a_letter_range, m_valid, (m_cipher_letter >= 7'h41) && (m_cipher_letter <= 7'h5A), "cipher letter out of range")

    // one word at a time: no intake while a result is shown
    `PF_ASSERT_NOW(a_no_overlap, m_valid, !s_ready, "input taken while result pending")

    // a result never follows an input word in the next cycle
    `PF_ASSERT_NEXT(a_min_latency, s_valid && s_ready, !m_valid, "result too soon after input")

    // the last word of a message ends the pair
    `PF_ASSERT_NEXT(a_last_ends, m_valid && m_ready && m_last, !m_valid, "result after last word")

endmodule

bind playfair_cipher_encrypt_core pf_checker u_pf_checker (.*);

/* test/testbench.sv */
// testbench for the playfair encryptor: key square, pair rules and handshakes against a local model
module testbench
    import pf_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORDS_WANTED = 1750;

    logic       aclk            = 1'b0;
    logic       aresetn         = 1'b0;
    logic       s_valid         = 1'b0;
    logic       s_ready;
    logic [1:0] s_req_type      = REQ_KEY_BYTE;
    logic [7:0] s_data_byte     = 8'h00;
    logic       m_valid;
    logic       m_ready         = 1'b0;
    logic [6:0] m_cipher_letter;
    logic       m_last;

    playfair_cipher_encrypt_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_data_byte     (s_data_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cipher_letter (m_cipher_letter),
        .m_last          (m_last)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    typedef struct packed {
        logic [6:0] letter;
        logic       last;
    } cipher_out_t;

    cipher_out_t letters_due[$];

    // local copy of the square and the open pair
    logic [4:0] sq_cell [CELLS];
    bit         sq_used [LETTERS];
    logic [4:0] sq_pos  [LETTERS];
    int         sq_fill     = 0;
    logic [4:0] open_letter = '0;
    bit         open_valid  = 1'b0;
    bit         sq_ready    = 1'b0;

    bit gaps_on   = 1'b1;
    bit stalls_on = 1'b1;
    int errors        = 0;
    int words_sent    = 0;
    int words_counted = 0;
    int keys_built    = 0;
    int results_seen  = 0;

    logic [7:0] near_letters [4] = '{8'h40, 8'h5B, 8'h60, 8'h7B};

    // letter index 0..25 with j folded onto i, -1 for anything else
    function automatic int fold_letter(logic [7:0] b);
        int v;
        v = b;
        if (v >= 97 && v <= 122) v -= 32;
        if (v < 65 || v > 90) return -1;
        v -= 65;
        return (v == int'(IDX_J)) ? int'(IDX_I) : v;
    endfunction

    function automatic void place_in_square(int idx);
        if (sq_used[idx] || sq_fill >= CELLS) return;
        sq_cell[sq_fill] = 5'(idx);
        sq_pos[idx]      = 5'(sq_fill);
        sq_used[idx]     = 1'b1;
        sq_fill++;
    endfunction

    function automatic void encrypt_pair(int a, int b, bit fin);
        int pa, pb, r1, c1, r2, c2, x, y;
        pa = sq_pos[a];
        pb = sq_pos[b];
        r1 = pa / SQUARE_SIDE;
        c1 = pa % SQUARE_SIDE;
        r2 = pb / SQUARE_SIDE;
        c2 = pb % SQUARE_SIDE;
        if (r1 == r2) begin
            x = sq_cell[r1 * SQUARE_SIDE + (c1 + 1) % SQUARE_SIDE];
            y = sq_cell[r2 * SQUARE_SIDE + (c2 + 1) % SQUARE_SIDE];
        end else if (c1 == c2) begin
            x = sq_cell[((r1 + 1) % SQUARE_SIDE) * SQUARE_SIDE + c1];
            y = sq_cell[((r2 + 1) % SQUARE_SIDE) * SQUARE_SIDE + c2];
        end else begin
            x = sq_cell[r1 * SQUARE_SIDE + c2];
            y = sq_cell[r2 * SQUARE_SIDE + c1];
        end
        letters_due.push_back('{7'(x) + LETTER_BASE, 1'b0});
        letters_due.push_back('{7'(y) + LETTER_BASE, fin});
    endfunction

    // returns 0 when the block just ignores the word
    function automatic bit playfair_step(req_type_t kind, logic [7:0] b);
        int idx;
        idx = fold_letter(b);
        case (kind)
            REQ_KEY_BYTE: begin
                if (sq_ready) begin
                    foreach (sq_used[k]) sq_used[k] = 1'b0;
                    sq_fill    = 0;
                    sq_ready   = 1'b0;
                    open_valid = 1'b0;
                end
                if (idx >= 0) place_in_square(idx);
                return 1'b1;
            end
            REQ_KEY_END: begin
                if (sq_ready) return 1'b0;
                for (int k = 0; k < LETTERS; k++) begin
                    if (k != int'(IDX_J)) place_in_square(k);
                end
                sq_ready   = 1'b1;
                open_valid = 1'b0;
                keys_built++;
                return 1'b1;
            end
            REQ_TEXT_BYTE: begin
                if (!sq_ready || idx < 0) return 1'b0;
                if (!open_valid) begin
                    open_letter = 5'(idx);
                    open_valid  = 1'b1;
                end else if (idx == int'(open_letter)) begin
                    // x goes in, the repeated letter stays open
                    encrypt_pair(open_letter, IDX_X, 1'b0);
                end else begin
                    encrypt_pair(open_letter, idx, 1'b0);
                    open_valid = 1'b0;
                end
                return 1'b1;
            end
            default: begin
                if (!sq_ready || !open_valid) return 1'b0;
                encrypt_pair(open_letter, IDX_X, 1'b1);
                open_valid = 1'b0;
                return 1'b1;
            end
        endcase
    endfunction

    task automatic send_word(req_type_t kind, logic [7:0] b);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_req_type  <= kind;
        s_data_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
        if (playfair_step(kind, b)) words_counted++;
    endtask

    task automatic send_chars(req_type_t kind, string s);
        foreach (s[i]) send_word(kind, s[i]);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (letters_due.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] letter_byte();
        logic [7:0] c;
        c = 8'h41 + 8'($urandom_range(0, 25));
        return $urandom_range(0, 1) ? c + 8'h20 : c;
    endfunction

    function automatic logic [7:0] noise_byte();
        return $urandom_range(0, 1) ? near_letters[$urandom_range(0, 3)] : 8'($urandom);
    endfunction

    function automatic logic [7:0] text_byte(logic [7:0] prev);
        int r;
        r = $urandom_range(0, 15);
        if (r < 3) return prev;
        if (r == 3) return $urandom_range(0, 1) ? 8'h58 : 8'h78;
        if (r == 4) return noise_byte();
        return letter_byte();
    endfunction

    task automatic test_text_before_key();
        send_word(REQ_TEXT_BYTE, 8'h61);
        send_word(REQ_TEXT_END, 8'hFF);
    endtask

    task automatic test_key_build();
        send_chars(REQ_KEY_BYTE, "Moj");
        send_word(REQ_KEY_BYTE, 8'hFF);
        send_word(REQ_KEY_BYTE, 8'h00);
        send_word(REQ_KEY_BYTE, 8'h6D);
        send_word(REQ_KEY_END, 8'h00);
        // square already complete, so this one is dropped
        send_word(REQ_KEY_END, 8'hFF);
    endtask

    task automatic test_pair_rules();
        // same row, same column, rectangle, then x x and a lone x at the end
        send_chars(REQ_TEXT_BYTE, "MbCQDzxX");
        send_word(REQ_TEXT_END, 8'h00);
        send_word(REQ_TEXT_END, 8'h00);
        drain_results();
    endtask

    task automatic test_double_letter();
        send_chars(REQ_TEXT_BYTE, "LL");
        send_word(REQ_TEXT_BYTE, 8'h80);
        send_word(REQ_TEXT_END, 8'h00);
        // keyword byte once the square is complete starts a new key
        send_word(REQ_KEY_BYTE, 8'h5A);
    endtask

    task automatic test_random_sessions();
        int         n_key;
        logic [7:0] prev;
        logic [7:0] b;
        while (words_sent < WORDS_WANTED) begin
            if (words_sent > WORDS_WANTED * 85 / 100) begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end else begin
                gaps_on   = $urandom_range(0, 3) != 0;
                stalls_on = $urandom_range(0, 3) != 0;
            end
            n_key = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 32) : $urandom_range(0, 8);
            repeat (n_key) begin
                send_word(REQ_KEY_BYTE, ($urandom_range(0, 7) == 0) ? noise_byte() : letter_byte());
            end
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 3)) send_word(REQ_TEXT_BYTE, letter_byte());
            end
            if ($urandom_range(0, 15) != 0) send_word(REQ_KEY_END, 8'($urandom));
            prev = letter_byte();
            repeat ($urandom_range(1, 40)) begin
                b = text_byte(prev);
                send_word(REQ_TEXT_BYTE, b);
                prev = b;
            end
            if ($urandom_range(0, 7) != 0) send_word(REQ_TEXT_END, 8'($urandom));
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    send_word(req_type_t'($urandom_range(0, 3)), 8'($urandom));
                end
            end
            if ($urandom_range(0, 11) == 0) drain_results();
        end
    endtask

    initial begin : result_sink
        forever begin
            @(posedge aclk);
            if (stalls_on && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_letters
        cipher_out_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (letters_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected word, letter %h last %b",
                         $time, m_cipher_letter, m_last);
            end else begin
                want = letters_due.pop_front();
                if (m_cipher_letter !== want.letter) begin
                    errors++;
                    $display("%0t: cipher letter expected %h got %h",
                             $time, want.letter, m_cipher_letter);
                end
                if (m_last !== want.last) begin
                    errors++;
                    $display("%0t: last expected %b got %b",
                             $time, want.last, m_last);
                end
            end
        end
    end

    initial begin : stimulus
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_text_before_key();
        test_key_build();
        test_pair_rules();
        test_double_letter();
        test_random_sessions();
        s_valid <= 1'b0;
        while (letters_due.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("summary: %0d words sent, %0d took effect, %0d squares built",
                 words_sent, words_counted, keys_built);
        $display("summary: %0d cipher letters checked, %0d mismatches", results_seen, errors);
        if (errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    initial begin : watchdog
        #2ms;
        $display("timeout with %0d cipher letters outstanding", letters_due.size());
        $display("testbench: errors");
        $finish;
    end

endmodule
